// ===== rtl/tsgf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsgf_pkg
// Shared types, codes and helpers of the timed sample gap filler: beat
// structs of both channels, the command passed from front to back end and
// the timestamp pull-back.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgf_pkg;

    // defaults for top-level parameters
    localparam int MAX_FILL_DEF    = 63;
    localparam int QUEUE_DEPTH_DEF = 2;

    // result sample kinds
    localparam logic [1:0] KIND_REAL   = 2'd0;
    localparam logic [1:0] KIND_INTERP = 2'd1;
    localparam logic [1:0] KIND_ZERO   = 2'd2;

    // input beat
    typedef struct packed {
        logic [31:0]        sample_sys_time;
        logic [31:0]        sample_hz_time;
        logic [31:0]        sample_ext_time;
        logic signed [31:0] sample_value;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [31:0]        out_sys_time;
        logic [31:0]        out_hz_time;
        logic [31:0]        out_ext_time;
        logic signed [31:0] out_value;
        logic [1:0]         sample_kind;
        logic               gap_clipped;
        logic               last_of_run;
    } out_beat_t;

    // one timestamped sample as held internally
    typedef struct packed {
        logic [31:0] sys;
        logic [31:0] hz;
        logic [31:0] ext;
        logic [31:0] val;
    } datum_t;

    // what the back end has to do for one accepted sample
    typedef enum logic [1:0] {
        CMD_REAL   = 2'd0,
        CMD_INTERP = 2'd1,
        CMD_ZFILL  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        clipped;
        logic [31:0] gap;
        datum_t      prev;
        datum_t      smp;
    } cmd_t;

    // pull hz and ext times back when hz runs ahead of system time
    function automatic datum_t pull_back(datum_t d);
        logic [31:0] diff;
        datum_t      r;
        begin
            r    = d;
            diff = d.hz - d.sys;
            if (d.sys < d.hz) begin
                r.hz  = d.sys;
                r.ext = d.ext - diff;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tsgf_front.sv =====
// ----------------------------------------------------------------------------
// tsgf_front
// Accepts input beats, drops early samples, snaps on-time samples to the
// slot and classifies the gap; keeps the previous emitted real sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgf_front #(
    parameter int MAX_FILL = tsgf_pkg::MAX_FILL_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire  [15:0]         sint,
    input  wire                 s_valid,
    output logic                s_ready,
    input  tsgf_pkg::in_beat_t  s_sample,
    input  wire                 q_full,
    output logic                q_push,
    output tsgf_pkg::cmd_t      q_cmd
);
    import tsgf_pkg::*;

    logic        awaiting_first_reg;
    datum_t      prev_reg;

    logic [31:0] sint32;
    logic [31:0] clip_thr;
    logic [31:0] slot;
    logic [31:0] gap;
    logic        accept;
    logic        early;
    logic        on_time;
    logic        one_miss;
    logic        clip;
    datum_t      smp;
    datum_t      smp_pb;

    assign sint32   = {16'd0, sint};
    assign clip_thr = sint32 * 32'(MAX_FILL + 1);

    // slot and gap classification
    assign slot     = prev_reg.sys + sint32;
    assign gap      = s_sample.sample_sys_time - slot;
    assign early    = !awaiting_first_reg && (s_sample.sample_sys_time < slot);
    assign on_time  = gap < sint32;
    assign one_miss = !on_time && (gap < {15'd0, sint, 1'b0});
    assign clip     = !on_time && !one_miss && (gap >= clip_thr);

    // snapped and pulled-back real sample
    always_comb begin
        smp.sys = (awaiting_first_reg || !on_time) ? s_sample.sample_sys_time : slot;
        smp.hz  = s_sample.sample_hz_time;
        smp.ext = s_sample.sample_ext_time;
        smp.val = s_sample.sample_value;
    end
    assign smp_pb = pull_back(smp);

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && !early;

    // command for the back end
    always_comb begin
        q_cmd.gap     = gap;
        q_cmd.prev    = prev_reg;
        q_cmd.smp     = smp_pb;
        q_cmd.clipped = !awaiting_first_reg && clip;
        if (awaiting_first_reg || on_time) begin
            q_cmd.kind = CMD_REAL;
        end else if (one_miss) begin
            q_cmd.kind = CMD_INTERP;
        end else begin
            q_cmd.kind = CMD_ZFILL;
        end
    end

    // first-sample flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_first_reg <= 1'b1;
        end else if (q_push) begin
            awaiting_first_reg <= 1'b0;
        end
    end

    // previous emitted real sample
    always_ff @(posedge aclk) begin
        if (q_push) begin
            prev_reg <= smp_pb;
        end
    end

    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && awaiting_first_reg) |=> !awaiting_first_reg)
        else $error("first sample did not clear the awaiting flag");

endmodule

`default_nettype wire

// ===== rtl/tsgf_queue.sv =====
// ----------------------------------------------------------------------------
// tsgf_queue
// Small command queue between front and back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgf_queue #(
    parameter int DEPTH = tsgf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  tsgf_pkg::cmd_t  push_cmd,
    output logic            full,
    input  wire             pop,
    output logic            not_empty,
    output tsgf_pkg::cmd_t  head_cmd
);
    import tsgf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== rtl/tsgf_back.sv =====
// ----------------------------------------------------------------------------
// tsgf_back
// Carries out queued commands: emits the interpolated or zero fills and
// then the real sample into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgf_back #(
    parameter int MAX_FILL = tsgf_pkg::MAX_FILL_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire  [15:0]         sint,
    input  wire                 q_not_empty,
    input  tsgf_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output tsgf_pkg::out_beat_t m_result
);
    import tsgf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FILL + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INTERP = 4'b0010,
        ST_ZFILL  = 4'b0100,
        ST_REAL   = 4'b1000
    } back_state_t;

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    datum_t           fill_reg, fill_next;
    logic [31:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_result_reg, m_result_next;

    logic [31:0]      sint32;
    logic             out_free;
    datum_t           fill_raw;
    datum_t           fill_pb;
    datum_t           interp_raw;
    datum_t           interp_pb;
    logic [32:0]      val_sum;
    logic [32:0]      val_adj;
    logic [31:0]      rem_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic             more_fill;

    assign sint32   = {16'd0, sint};
    assign out_free = !m_valid_reg || m_ready;

    // next zero fill, one interval on from the last one
    always_comb begin
        fill_raw.sys = fill_reg.sys + sint32;
        fill_raw.hz  = fill_reg.hz + sint32;
        fill_raw.ext = fill_reg.ext + sint32;
        fill_raw.val = '0;
    end
    assign fill_pb = pull_back(fill_raw);

    // interpolated fill, average truncated toward zero
    assign val_sum = {cmd_reg.prev.val[31], cmd_reg.prev.val}
                   + {cmd_reg.smp.val[31], cmd_reg.smp.val};
    assign val_adj = val_sum + {32'd0, val_sum[32]};
    always_comb begin
        interp_raw.sys = cmd_reg.prev.sys + sint32;
        interp_raw.hz  = cmd_reg.prev.hz + sint32;
        interp_raw.ext = cmd_reg.prev.ext + sint32;
        interp_raw.val = val_adj[32:1];
    end
    assign interp_pb = pull_back(interp_raw);

    // fill loop bookkeeping
    assign rem_dec   = rem_reg - sint32;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign more_fill = (rem_dec >= sint32) && (cnt_inc != CNT_W'(MAX_FILL));

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        fill_next     = fill_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        q_pop         = 1'b0;
        m_result_next = m_result_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    fill_next = q_cmd.prev;
                    rem_next  = q_cmd.gap;
                    cnt_next  = '0;
                    case (q_cmd.kind)
                        CMD_INTERP: state_next = ST_INTERP;
                        CMD_ZFILL:  state_next = ST_ZFILL;
                        default:    state_next = ST_REAL;
                    endcase
                end
            end
            ST_INTERP: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_result_next.out_sys_time = interp_pb.sys;
                    m_result_next.out_hz_time  = interp_pb.hz;
                    m_result_next.out_ext_time = interp_pb.ext;
                    m_result_next.out_value    = interp_pb.val;
                    m_result_next.sample_kind  = KIND_INTERP;
                    m_result_next.gap_clipped  = 1'b0;
                    m_result_next.last_of_run  = 1'b0;
                    state_next                 = ST_REAL;
                end
            end
            ST_ZFILL: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_result_next.out_sys_time = fill_pb.sys;
                    m_result_next.out_hz_time  = fill_pb.hz;
                    m_result_next.out_ext_time = fill_pb.ext;
                    m_result_next.out_value    = fill_pb.val;
                    m_result_next.sample_kind  = KIND_ZERO;
                    m_result_next.gap_clipped  = cmd_reg.clipped;
                    m_result_next.last_of_run  = 1'b0;
                    fill_next                  = fill_pb;
                    rem_next                   = rem_dec;
                    cnt_next                   = cnt_inc;
                    state_next                 = more_fill ? ST_ZFILL : ST_REAL;
                end
            end
            ST_REAL: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_result_next.out_sys_time = cmd_reg.smp.sys;
                    m_result_next.out_hz_time  = cmd_reg.smp.hz;
                    m_result_next.out_ext_time = cmd_reg.smp.ext;
                    m_result_next.out_value    = cmd_reg.smp.val;
                    m_result_next.sample_kind  = KIND_REAL;
                    m_result_next.gap_clipped  = cmd_reg.clipped;
                    m_result_next.last_of_run  = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        fill_reg     <= fill_next;
        rem_reg      <= rem_next;
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_last_is_real: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_result_reg.last_of_run) |-> (m_result_reg.sample_kind == KIND_REAL))
        else $error("last beat of a run is not the real sample");

    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FILL))
        else $error("zero fill count ran past the cap");

endmodule

`default_nettype wire

// ===== rtl/timed_sample_gap_filler.sv =====
// ----------------------------------------------------------------------------
// timed_sample_gap_filler
// Regularises timestamped sensor samples to a fixed interval, filling
// missed slots with interpolated or zero-valued samples.
// ----------------------------------------------------------------------------
// Usage
//   s_* : input beats (system, hz, external time and signed value).
//   m_* : result beats; one input gives up to MAX_FILL + 1 of them, the last
//         one flagged by last_of_run. Early samples give none.
//   cfg_*: writes sample_interval (0 acts as 1); always ready, write only
//         while no sample is in flight.
// Timing
//   an input beat is pushed into the command queue in the accept cycle; the
//   back end pops it once idle into its command register, and the first
//   result is then registered in the output stage. The back end takes one
//   item at a time and emits one result per cycle from the fill sequencer
//   while the output is not stalled; the front end keeps taking beats until
//   the command queue is full.
// Reset and stalls
//   reset clears the interval to 1, empties the queue and the output stage
//   and rearms pass-through of the first sample. A stalled m_ready holds
//   the output register; the back end then waits and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_sample_gap_filler #(
    parameter int MAX_FILL    = tsgf_pkg::MAX_FILL_DEF,
    parameter int QUEUE_DEPTH = tsgf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  tsgf_pkg::in_beat_t  s_sample,
    output logic                m_valid,
    input  wire                 m_ready,
    output tsgf_pkg::out_beat_t m_result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [15:0]         cfg_data
);
    import tsgf_pkg::*;

    logic [15:0] interval_reg;
    logic [15:0] sint;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    cmd_t        push_cmd;
    cmd_t        head_cmd;

    // interval register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            interval_reg <= cfg_data;
        end
    end

    assign sint = (interval_reg == 16'd0) ? 16'd1 : interval_reg;

    tsgf_front #(
        .MAX_FILL (MAX_FILL)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sint     (sint),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    tsgf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    tsgf_back #(
        .MAX_FILL (MAX_FILL)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sint        (sint),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

endmodule

`default_nettype wire
